### hw/rtl/arbb_pkg.sv
package arbb_pkg;

	// coordinate width of the result fields
	localparam int COORD_BITS = 13;

	// field widths
	localparam int RECT_POS_W = 12;
	localparam int RECT_LEN_W = 13;
	localparam int IMG_W      = 13;
	localparam int COEF_W     = 24;
	localparam int OFFS_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 4;

	// corner coordinate: position plus length, no wrap
	localparam int CORNER_W = RECT_LEN_W + 1;
	// products, accumulator and mapped pixel
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = COEF_W + CORNER_W + 1;
	localparam int ACC_W     = PROD_W + 2;
	localparam int PIX_W     = ACC_W - FRAC_BITS;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX   = 4'd0,
		REG_COEF_XY   = 4'd1,
		REG_OFFSET_X  = 4'd2,
		REG_COEF_YX   = 4'd3,
		REG_COEF_YY   = 4'd4,
		REG_OFFSET_Y  = 4'd5,
		REG_IMG_WIDTH = 4'd6,
		REG_IMG_HEIGHT = 4'd7
	} reg_idx_t;

	// register reset values
	localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd65536;
	localparam logic [IMG_W-1:0] IMG_SIZE_RST = 13'd4096;

	typedef logic signed [PIX_W-1:0] pix_t;

	// input transaction
	typedef struct packed {
		logic [RECT_POS_W-1:0] rect_x;
		logic [RECT_POS_W-1:0] rect_y;
		logic [RECT_LEN_W-1:0] rect_width;
		logic [RECT_LEN_W-1:0] rect_height;
	} rect_t;

	// output transaction
	typedef struct packed {
		logic [COORD_BITS-1:0] box_x;
		logic [COORD_BITS-1:0] box_y;
		logic [COORD_BITS-1:0] box_width;
		logic [COORD_BITS-1:0] box_height;
	} box_t;

	// pipeline load enables for the mapping stages
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} map_ctl_t;

endpackage

### hw/rtl/arbb_axis.sv
module arbb_axis (
	input  logic                                 clk,
	input  arbb_pkg::map_ctl_t                   ctl,
	input  logic signed [arbb_pkg::COEF_W-1:0]   coef_a,
	input  logic signed [arbb_pkg::COEF_W-1:0]   coef_b,
	input  logic signed [arbb_pkg::OFFS_W-1:0]   offset,
	input  logic [arbb_pkg::CORNER_W-1:0]        x0_s1,
	input  logic [arbb_pkg::CORNER_W-1:0]        x1_s1,
	input  logic [arbb_pkg::CORNER_W-1:0]        y0_s1,
	input  logic [arbb_pkg::CORNER_W-1:0]        y1_s1,
	output arbb_pkg::pix_t                       pix_s3 [4]
);
	import arbb_pkg::*;

	logic signed [CORNER_W:0] xs [2];
	logic signed [CORNER_W:0] ys [2];
	logic signed [PROD_W-1:0] pa_s2 [2];
	logic signed [PROD_W-1:0] pb_s2 [2];
	logic signed [ACC_W-1:0]  acc [4];
	pix_t                     pix [4];

	assign xs[0] = signed'({1'b0, x0_s1});
	assign xs[1] = signed'({1'b0, x1_s1});
	assign ys[0] = signed'({1'b0, y0_s1});
	assign ys[1] = signed'({1'b0, y1_s1});

	// one product per edge coordinate, shared by two corners
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int i = 0; i < 2; i++) begin
				pa_s2[i] <= coef_a * xs[i];
				pb_s2[i] <= coef_b * ys[i];
			end
		end
	end

	// corner sum and truncation toward zero, corner k = 2*i + j
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			acc[k] = ACC_W'(pa_s2[k / 2]) + ACC_W'(pb_s2[k % 2]) + ACC_W'(offset);
			pix[k] = acc[k][ACC_W-1:FRAC_BITS];
			if (acc[k][ACC_W-1] && (acc[k][FRAC_BITS-1:0] != '0)) begin
				pix[k] = pix[k] + PIX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			for (int k = 0; k < 4; k++) begin
				pix_s3[k] <= pix[k];
			end
		end
	end

endmodule

### hw/rtl/affine_rect_bounding_box.sv
// channel   | valid     | stall     | payload  | moves
// ----------+-----------+-----------+----------+-------------------------------
// input     | in_valid  | in_stall  | in_data  | one rectangle per transaction
// output    | out_valid | out_stall | out_data | one box per rectangle
// config    | cfg_write | -         | cfg_data | register cfg_index, no wait
//
// one rectangle per cycle sustained while out_stall is low; five register stages
// (corner add, products, corner sums, min/max/clamp, centering) before out_valid
// reset restores the identity matrix and a 4096 by 4096 image, pipeline empty
// a stalled output holds its box; stages behind it keep filling, and in_stall
// rises only once every stage holds a transaction
module affine_rect_bounding_box (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  arbb_pkg::rect_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output arbb_pkg::box_t                      out_data,
	input  logic                                cfg_write,
	input  logic [arbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arbb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import arbb_pkg::*;

	// configuration registers
	logic signed [COEF_W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
	logic signed [OFFS_W-1:0] offset_x_q, offset_y_q;
	logic [IMG_W-1:0]         img_width_q, img_height_q;

	// pipeline valid bits and enables
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_res;
	map_ctl_t map_ctl;

	// stage data
	logic [CORNER_W-1:0]   x0_s1, x1_s1, y0_s1, y1_s1;
	logic [RECT_LEN_W-1:0] rw_s1, rh_s1, rw_s2, rh_s2, rw_s3, rh_s3, rw_s4, rh_s4;
	pix_t                  px_s3 [4];
	pix_t                  py_s3 [4];
	logic [IMG_W-1:0]      xmin_s4, xmax_s4, ymin_s4, ymax_s4;
	box_t                  res_q;

	// combinational helpers
	pix_t             xmin_c, xmax_c, ymin_c, ymax_c;
	logic [IMG_W-1:0] bw_c, bh_c;
	box_t             box_c;

	function automatic pix_t min2(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(pix_t a, pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [IMG_W-1:0] clamp_pix(pix_t v, logic [IMG_W-1:0] hi);
		pix_t hi_s;
		hi_s = signed'(PIX_W'(hi));
		if (v < 0) begin
			return '0;
		end else if (v > hi_s) begin
			return hi;
		end
		return v[IMG_W-1:0];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q    <= COEF_ONE;
			coef_xy_q    <= '0;
			offset_x_q   <= '0;
			coef_yx_q    <= '0;
			coef_yy_q    <= COEF_ONE;
			offset_y_q   <= '0;
			img_width_q  <= IMG_SIZE_RST;
			img_height_q <= IMG_SIZE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COEF_XX:    coef_xx_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_XY:    coef_xy_q    <= cfg_data[COEF_W-1:0];
				REG_OFFSET_X:   offset_x_q   <= cfg_data[OFFS_W-1:0];
				REG_COEF_YX:    coef_yx_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_YY:    coef_yy_q    <= cfg_data[COEF_W-1:0];
				REG_OFFSET_Y:   offset_y_q   <= cfg_data[OFFS_W-1:0];
				REG_IMG_WIDTH:  img_width_q  <= cfg_data[IMG_W-1:0];
				REG_IMG_HEIGHT: img_height_q <= cfg_data[IMG_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one loads
	assign en_res   = !res_valid_q || !out_stall;
	assign en_s4    = !v_s4 || en_res;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign map_ctl  = '{en_s2: en_s2, en_s3: en_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= in_valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_s4)  v_s4        <= v_s3;
			if (en_res) res_valid_q <= v_s4;
		end
	end

	// stage 1: corner coordinates
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x0_s1 <= CORNER_W'(in_data.rect_x);
			x1_s1 <= CORNER_W'(in_data.rect_x) + CORNER_W'(in_data.rect_width);
			y0_s1 <= CORNER_W'(in_data.rect_y);
			y1_s1 <= CORNER_W'(in_data.rect_y) + CORNER_W'(in_data.rect_height);
			rw_s1 <= in_data.rect_width;
			rh_s1 <= in_data.rect_height;
		end
	end

	// stages 2 and 3: corner mapping per axis
	arbb_axis u_axis_x (
		.clk    (clk),
		.ctl    (map_ctl),
		.coef_a (coef_xx_q),
		.coef_b (coef_xy_q),
		.offset (offset_x_q),
		.x0_s1  (x0_s1),
		.x1_s1  (x1_s1),
		.y0_s1  (y0_s1),
		.y1_s1  (y1_s1),
		.pix_s3 (px_s3)
	);

	arbb_axis u_axis_y (
		.clk    (clk),
		.ctl    (map_ctl),
		.coef_a (coef_yx_q),
		.coef_b (coef_yy_q),
		.offset (offset_y_q),
		.x0_s1  (x0_s1),
		.x1_s1  (x1_s1),
		.y0_s1  (y0_s1),
		.y1_s1  (y1_s1),
		.pix_s3 (py_s3)
	);

	// source size rides along with the mapping stages
	always_ff @(posedge clk) begin
		if (en_s2) begin
			rw_s2 <= rw_s1;
			rh_s2 <= rh_s1;
		end
		if (en_s3) begin
			rw_s3 <= rw_s2;
			rh_s3 <= rh_s2;
		end
	end

	// stage 4: extremes over the four corners, then clamp to the image
	always_comb begin
		xmin_c = min2(min2(px_s3[0], px_s3[1]), min2(px_s3[2], px_s3[3]));
		xmax_c = max2(max2(px_s3[0], px_s3[1]), max2(px_s3[2], px_s3[3]));
		ymin_c = min2(min2(py_s3[0], py_s3[1]), min2(py_s3[2], py_s3[3]));
		ymax_c = max2(max2(py_s3[0], py_s3[1]), max2(py_s3[2], py_s3[3]));
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			xmin_s4 <= clamp_pix(xmin_c, img_width_q);
			xmax_s4 <= clamp_pix(xmax_c, img_width_q);
			ymin_s4 <= clamp_pix(ymin_c, img_height_q);
			ymax_s4 <= clamp_pix(ymax_c, img_height_q);
			rw_s4   <= rw_s3;
			rh_s4   <= rh_s3;
		end
	end

	// result: cut an oversized box to the source size, centered by half the excess
	always_comb begin
		bw_c = xmax_s4 - xmin_s4;
		bh_c = ymax_s4 - ymin_s4;
		box_c.box_x      = COORD_BITS'(xmin_s4);
		box_c.box_width  = COORD_BITS'(bw_c);
		box_c.box_y      = COORD_BITS'(ymin_s4);
		box_c.box_height = COORD_BITS'(bh_c);
		if (bw_c > rw_s4) begin
			box_c.box_x     = COORD_BITS'(xmin_s4 + ((bw_c - rw_s4) >> 1));
			box_c.box_width = COORD_BITS'(rw_s4);
		end
		if (bh_c > rh_s4) begin
			box_c.box_y      = COORD_BITS'(ymin_s4 + ((bh_c - rh_s4) >> 1));
			box_c.box_height = COORD_BITS'(rh_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en_res) begin
			res_q <= box_c;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule

### hw/rtl/arbb_checker.sv
module arbb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input arbb_pkg::box_t  out_data
);
	import arbb_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// input backs up only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// box stays inside the clamp range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((COORD_BITS + 1)'(out_data.box_x) + (COORD_BITS + 1)'(out_data.box_width))
			< (COORD_BITS + 1)'(1 << COORD_BITS))
		else $error("box right edge out of range");

	// an accepted transaction reaches the output while out_stall stays low behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
			|=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind affine_rect_bounding_box arbb_checker u_arbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
